### rtl/core/text_console_writer_defines.svh
// Assertion macros shared by the text console writer RTL
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tcw_pkg.sv
// Shared types and constants of the text console writer
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = 16;
    localparam int ADDR_IN_W = 11;
    localparam int POS_OUT_W = 11;

    localparam logic [CMD_W-1:0] CMD_PRINT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    typedef enum logic [2:0] {
        K_PRINT,
        K_LF,
        K_CR,
        K_BS,
        K_CLEAR,
        K_READ,
        K_NOP
    } kind_t;

    typedef enum logic [2:0] {
        COL_HOLD,
        COL_ZERO,
        COL_INC,
        COL_DEC,
        COL_LAST
    } col_op_t;

    typedef enum logic [1:0] {
        BASE_HOLD,
        BASE_ZERO,
        BASE_ADD,
        BASE_SUB
    } base_op_t;

    typedef enum logic [1:0] {
        SWEEP_HOLD,
        SWEEP_ZERO,
        SWEEP_INC
    } sweep_op_t;

    typedef enum logic [1:0] {
        WA_CURSOR,
        WA_CURSOR_M1,
        WA_SWEEP
    } wa_sel_t;

    typedef enum logic [1:0] {
        RA_ITEM,
        RA_CURSOR_M1,
        RA_SWEEP_ROW
    } ra_sel_t;

    typedef enum logic [2:0] {
        WD_LIVE_CHAR,
        WD_HELD_CHAR,
        WD_BLANK,
        WD_RESET_BLANK,
        WD_COPY
    } wd_sel_t;

    typedef struct packed {
        logic      latch;
        col_op_t   col_op;
        base_op_t  base_op;
        sweep_op_t sweep_op;
        logic      wr_en;
        wa_sel_t   wa_sel;
        wd_sel_t   wd_sel;
        logic      rd_en;
        ra_sel_t   ra_sel;
        logic      load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  col_zero;
        logic  col_full;
        logic  base_zero;
        logic  base_last;
        logic  rd_space;
        logic  sweep_last;
        logic  sweep_copy_end;
    } ctrl_status_t;

endpackage

`default_nettype wire

### rtl/core/tcw_item_if.sv
// Input word channel: command, byte to print and cell address
`default_nettype none

interface tcw_item_if;
    logic                           valid;
    logic                           ready;
    logic [tcw_pkg::CMD_W-1:0]      cmd;
    logic [tcw_pkg::CHAR_W-1:0]     char_code;
    logic [tcw_pkg::ADDR_IN_W-1:0]  cell_address;

    modport source (output valid, cmd, char_code, cell_address, input ready);
    modport sink   (input valid, cmd, char_code, cell_address, output ready);
endinterface

`default_nettype wire

### rtl/core/tcw_result_if.sv
// Result word channel: cursor position and cell value
`default_nettype none

interface tcw_result_if;
    logic                           valid;
    logic                           ready;
    logic [tcw_pkg::POS_OUT_W-1:0]  cursor_position;
    logic [tcw_pkg::CELL_W-1:0]     cell_value;

    modport source (output valid, cursor_position, cell_value, input ready);
    modport sink   (input valid, cursor_position, cell_value, output ready);
endinterface

`default_nettype wire

### rtl/core/tcw_cfg_if.sv
// Configuration write channel carrying the text attribute
`default_nettype none

interface tcw_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::ATTR_W-1:0]  text_attribute;

    modport source (output valid, text_attribute, input ready);
    modport sink   (input valid, text_attribute, output ready);
endinterface

`default_nettype wire

### rtl/core/text_console_writer.sv
// Text console writer: teletype console over a ROWS x COLUMNS buffer of attribute/char cells.
// Channels: item (cmd, char_code, cell_address) in, result (cursor_position, cell_value)
// out, cfg writes the text attribute and is always ready. One result word per item word.
// Steps the controller walks per item over the screen memory:
//   printable byte, CR, read, unused command, LF off the last row,
//   backspace within a row or at the top-left cell: accept step, then the final step
//   printable byte wrapping onto a new row (no scroll): accept, store, final step
//   LF or wrap on the last row (scroll): accept, a read and a write per copied cell, a blank
//   write per cell of the last row, the byte store if one waits, final step
//   clear screen: accept, a blank write per cell, final step
//   backspace at row start: read, a blank write or a walk over trailing blanks, final step
// The result register is loaded in the final step, after the item's last memory access.
// After reset the memory is filled with blanks in the reset attribute, one cell a cycle,
// with item.ready low; cfg writes are taken during that pass.
// When the receiver stalls the result word is held; one more item is taken and worked
// through, then the block waits in its final step until the result register is free.
`default_nettype none
`include "text_console_writer_defines.svh"

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tcw_item_if.sink      item,
    tcw_result_if.source  result,
    tcw_cfg_if.sink       cfg
);

    tcw_pkg::ctrl_cmd_t    ctrl;
    tcw_pkg::ctrl_status_t status;
    logic                  item_ready;
    logic                  result_valid;

    assign cfg.ready    = 1'b1;
    assign item.ready   = item_ready;
    assign result.valid = result_valid;

    tcw_controller u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item_ready),
        .result_ready (result.ready),
        .result_valid (result_valid),
        .status       (status),
        .ctrl         (ctrl)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_cmd        (item.cmd),
        .item_char       (item.char_code),
        .item_addr       (item.cell_address),
        .cfg_write       (cfg.valid),
        .cfg_attr        (cfg.text_attribute),
        .ctrl            (ctrl),
        .status          (status),
        .cursor_position (result.cursor_position),
        .cell_value      (result.cell_value)
    );

    // an accepted word always keeps the block busy: ready does not stay high after an accept
    `TCW_ASSERT_NEXT(a_busy_after_accept, item.valid && item_ready, !item_ready,
                     "ready after accept")

    // result register only loaded when the previous word has gone or is leaving
    `TCW_ASSERT_HOLDS(a_load_when_free, ctrl.load_result, !result_valid || result.ready,
                      "result overwritten")

    // a byte stored at the cursor never lands past the end of the row
    `TCW_ASSERT_HOLDS(a_cursor_write_in_row,
                      ctrl.wr_en && (ctrl.wa_sel == tcw_pkg::WA_CURSOR),
                      !status.col_full, "write at full row")

endmodule

`default_nettype wire

### rtl/core/tcw_datapath.sv
// Datapath: screen memory, cursor, sweep counter, attribute and result registers
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [tcw_pkg::CMD_W-1:0]      item_cmd,
    input  wire logic [tcw_pkg::CHAR_W-1:0]     item_char,
    input  wire logic [tcw_pkg::ADDR_IN_W-1:0]  item_addr,
    input  wire logic                           cfg_write,
    input  wire logic [tcw_pkg::ATTR_W-1:0]     cfg_attr,
    input  wire tcw_pkg::ctrl_cmd_t             ctrl,
    output tcw_pkg::ctrl_status_t               status,
    output logic [tcw_pkg::POS_OUT_W-1:0]       cursor_position,
    output logic [tcw_pkg::CELL_W-1:0]          cell_value
);

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int WIDE_W    = ADDR_W + 1;
    localparam int COL_W     = $clog2(COLUMNS + 1);
    localparam int CMP_W     = (WIDE_W > tcw_pkg::ADDR_IN_W) ? WIDE_W : tcw_pkg::ADDR_IN_W;
    localparam int POS_W     = WIDE_W + tcw_pkg::POS_OUT_W;
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
    localparam int COPY_END  = CELLS - COLUMNS - 1;

    logic [tcw_pkg::CELL_W-1:0]  mem [CELLS];

    logic [tcw_pkg::ATTR_W-1:0]  attr_reg;
    logic [tcw_pkg::CHAR_W-1:0]  char_reg;
    logic                        read_hit_reg;
    logic [COL_W-1:0]            col_reg;
    logic [COL_W-1:0]            col_next;
    logic [ADDR_W-1:0]           base_reg;
    logic [ADDR_W-1:0]           base_next;
    logic [ADDR_W-1:0]           sweep_reg;
    logic [ADDR_W-1:0]           sweep_next;
    logic [tcw_pkg::CELL_W-1:0]  rdata_reg;
    logic [tcw_pkg::POS_OUT_W-1:0] pos_reg;
    logic [tcw_pkg::CELL_W-1:0]  cell_reg;

    logic [CMP_W-1:0]            item_addr_ext;
    logic                        in_range;
    logic [WIDE_W-1:0]           cur_sum;
    logic [WIDE_W-1:0]           cur_m1_sum;
    logic [WIDE_W-1:0]           sweep_row_sum;
    logic [WIDE_W-1:0]           base_add_sum;
    logic [WIDE_W-1:0]           base_sub_sum;
    logic [POS_W-1:0]            pos_wide;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic [tcw_pkg::CELL_W-1:0]  wr_data;
    logic [tcw_pkg::CELL_W-1:0]  blank;
    tcw_pkg::kind_t              kind;

    assign item_addr_ext = CMP_W'(item_addr);
    assign in_range      = item_addr_ext < CMP_W'(CELLS);

    assign cur_sum       = WIDE_W'(base_reg) + WIDE_W'(col_reg);
    assign cur_m1_sum    = cur_sum - WIDE_W'(1);
    assign sweep_row_sum = WIDE_W'(sweep_reg) + WIDE_W'(COLUMNS);
    assign base_add_sum  = WIDE_W'(base_reg) + WIDE_W'(COLUMNS);
    assign base_sub_sum  = WIDE_W'(base_reg) - WIDE_W'(COLUMNS);
    assign pos_wide      = POS_W'(base_reg) + POS_W'(col_reg);

    assign blank = {attr_reg, tcw_pkg::CHAR_SPACE};

    always_comb
    begin
        unique case (item_cmd)
            tcw_pkg::CMD_PRINT:
            begin
                unique case (item_char)
                    tcw_pkg::CHAR_LF: kind = tcw_pkg::K_LF;
                    tcw_pkg::CHAR_CR: kind = tcw_pkg::K_CR;
                    tcw_pkg::CHAR_BS: kind = tcw_pkg::K_BS;
                    default:          kind = tcw_pkg::K_PRINT;
                endcase
            end
            tcw_pkg::CMD_CLEAR: kind = tcw_pkg::K_CLEAR;
            tcw_pkg::CMD_READ:  kind = tcw_pkg::K_READ;
            default:            kind = tcw_pkg::K_NOP;
        endcase
    end

    always_comb
    begin
        status.kind           = kind;
        status.col_zero       = col_reg == '0;
        status.col_full       = col_reg == COL_W'(COLUMNS);
        status.base_zero      = base_reg == '0;
        status.base_last      = base_reg == ADDR_W'(LAST_BASE);
        status.rd_space       = rdata_reg[tcw_pkg::CHAR_W-1:0] == tcw_pkg::CHAR_SPACE;
        status.sweep_last     = sweep_reg == ADDR_W'(CELLS - 1);
        status.sweep_copy_end = sweep_reg == ADDR_W'(COPY_END);
    end

    always_comb
    begin
        unique case (ctrl.wa_sel)
            tcw_pkg::WA_CURSOR:    wr_addr = cur_sum[ADDR_W-1:0];
            tcw_pkg::WA_CURSOR_M1: wr_addr = cur_m1_sum[ADDR_W-1:0];
            default:               wr_addr = sweep_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.ra_sel)
            tcw_pkg::RA_ITEM:      rd_addr = item_addr_ext[ADDR_W-1:0];
            tcw_pkg::RA_CURSOR_M1: rd_addr = cur_m1_sum[ADDR_W-1:0];
            default:               rd_addr = sweep_row_sum[ADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        unique case (ctrl.wd_sel)
            tcw_pkg::WD_LIVE_CHAR:   wr_data = {attr_reg, item_char};
            tcw_pkg::WD_HELD_CHAR:   wr_data = {attr_reg, char_reg};
            tcw_pkg::WD_BLANK:       wr_data = blank;
            tcw_pkg::WD_RESET_BLANK: wr_data = {tcw_pkg::ATTR_RESET, tcw_pkg::CHAR_SPACE};
            default:                 wr_data = rdata_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.col_op)
            tcw_pkg::COL_ZERO: col_next = '0;
            tcw_pkg::COL_INC:  col_next = col_reg + COL_W'(1);
            tcw_pkg::COL_DEC:  col_next = col_reg - COL_W'(1);
            tcw_pkg::COL_LAST: col_next = COL_W'(COLUMNS - 1);
            default:           col_next = col_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.base_op)
            tcw_pkg::BASE_ZERO: base_next = '0;
            tcw_pkg::BASE_ADD:  base_next = base_add_sum[ADDR_W-1:0];
            tcw_pkg::BASE_SUB:  base_next = base_sub_sum[ADDR_W-1:0];
            default:            base_next = base_reg;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.sweep_op)
            tcw_pkg::SWEEP_ZERO: sweep_next = '0;
            tcw_pkg::SWEEP_INC:  sweep_next = sweep_reg + ADDR_W'(1);
            default:             sweep_next = sweep_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg  <= tcw_pkg::ATTR_RESET;
            col_reg   <= '0;
            base_reg  <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                attr_reg <= cfg_attr;
            end
            col_reg   <= col_next;
            base_reg  <= base_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            char_reg     <= item_char;
            read_hit_reg <= (kind == tcw_pkg::K_READ) && in_range;
        end
        if (ctrl.load_result)
        begin
            pos_reg  <= pos_wide[tcw_pkg::POS_OUT_W-1:0];
            cell_reg <= read_hit_reg ? rdata_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign cursor_position = pos_reg;
    assign cell_value      = cell_reg;

endmodule

`default_nettype wire

### rtl/core/tcw_controller.sv
// Controller: sequences each word through the datapath and holds the result flag
`default_nettype none

module tcw_controller (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire logic                   result_ready,
    output logic                        result_valid,
    input  wire tcw_pkg::ctrl_status_t  status,
    output tcw_pkg::ctrl_cmd_t          ctrl
);

    localparam logic [3:0] S_INIT     = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_FINISH   = 4'd2;
    localparam logic [3:0] S_CLEAR    = 4'd3;
    localparam logic [3:0] S_SCR_RD   = 4'd4;
    localparam logic [3:0] S_SCR_WR   = 4'd5;
    localparam logic [3:0] S_FILL     = 4'd6;
    localparam logic [3:0] S_PUT      = 4'd7;
    localparam logic [3:0] S_BS_FIRST = 4'd8;
    localparam logic [3:0] S_BS_RD    = 4'd9;
    localparam logic [3:0] S_BS_CHK   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       then_put_reg;
    logic       then_put_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        ctrl          = '0;
        state_next    = state_reg;
        then_put_next = then_put_reg;
        item_ready    = 1'b0;

        unique case (state_reg)
            S_INIT:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.wa_sel = tcw_pkg::WA_SWEEP;
                ctrl.wd_sel = tcw_pkg::WD_RESET_BLANK;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctrl.sweep_op = tcw_pkg::SWEEP_INC;
                end
            end

            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    ctrl.latch    = 1'b1;
                    ctrl.sweep_op = tcw_pkg::SWEEP_ZERO;
                    then_put_next = status.kind == tcw_pkg::K_PRINT;
                    state_next    = S_FINISH;
                    unique case (status.kind)
                        tcw_pkg::K_PRINT:
                        begin
                            if (status.col_full)
                            begin
                                // row full: new line first, then store the byte
                                ctrl.col_op = tcw_pkg::COL_ZERO;
                                if (status.base_last)
                                begin
                                    state_next = S_SCR_RD;
                                end
                                else
                                begin
                                    ctrl.base_op = tcw_pkg::BASE_ADD;
                                    state_next   = S_PUT;
                                end
                            end
                            else
                            begin
                                ctrl.wr_en  = 1'b1;
                                ctrl.wa_sel = tcw_pkg::WA_CURSOR;
                                ctrl.wd_sel = tcw_pkg::WD_LIVE_CHAR;
                                ctrl.col_op = tcw_pkg::COL_INC;
                            end
                        end
                        tcw_pkg::K_LF:
                        begin
                            ctrl.col_op = tcw_pkg::COL_ZERO;
                            if (status.base_last)
                            begin
                                state_next = S_SCR_RD;
                            end
                            else
                            begin
                                ctrl.base_op = tcw_pkg::BASE_ADD;
                            end
                        end
                        tcw_pkg::K_CR:
                        begin
                            ctrl.col_op = tcw_pkg::COL_ZERO;
                        end
                        tcw_pkg::K_BS:
                        begin
                            if (!status.col_zero)
                            begin
                                ctrl.col_op = tcw_pkg::COL_DEC;
                                ctrl.wr_en  = 1'b1;
                                ctrl.wa_sel = tcw_pkg::WA_CURSOR_M1;
                                ctrl.wd_sel = tcw_pkg::WD_BLANK;
                            end
                            else if (!status.base_zero)
                            begin
                                // fetch last cell of the row above
                                ctrl.base_op = tcw_pkg::BASE_SUB;
                                ctrl.col_op  = tcw_pkg::COL_LAST;
                                ctrl.rd_en   = 1'b1;
                                ctrl.ra_sel  = tcw_pkg::RA_CURSOR_M1;
                                state_next   = S_BS_FIRST;
                            end
                        end
                        tcw_pkg::K_CLEAR:
                        begin
                            state_next = S_CLEAR;
                        end
                        tcw_pkg::K_READ:
                        begin
                            ctrl.rd_en  = 1'b1;
                            ctrl.ra_sel = tcw_pkg::RA_ITEM;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.wa_sel = tcw_pkg::WA_SWEEP;
                ctrl.wd_sel = tcw_pkg::WD_BLANK;
                if (status.sweep_last)
                begin
                    ctrl.base_op = tcw_pkg::BASE_ZERO;
                    ctrl.col_op  = tcw_pkg::COL_ZERO;
                    state_next   = S_FINISH;
                end
                else
                begin
                    ctrl.sweep_op = tcw_pkg::SWEEP_INC;
                end
            end

            S_SCR_RD:
            begin
                ctrl.rd_en  = 1'b1;
                ctrl.ra_sel = tcw_pkg::RA_SWEEP_ROW;
                state_next  = S_SCR_WR;
            end

            S_SCR_WR:
            begin
                ctrl.wr_en    = 1'b1;
                ctrl.wa_sel   = tcw_pkg::WA_SWEEP;
                ctrl.wd_sel   = tcw_pkg::WD_COPY;
                ctrl.sweep_op = tcw_pkg::SWEEP_INC;
                state_next    = status.sweep_copy_end ? S_FILL : S_SCR_RD;
            end

            S_FILL:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.wa_sel = tcw_pkg::WA_SWEEP;
                ctrl.wd_sel = tcw_pkg::WD_BLANK;
                if (status.sweep_last)
                begin
                    state_next = then_put_reg ? S_PUT : S_FINISH;
                end
                else
                begin
                    ctrl.sweep_op = tcw_pkg::SWEEP_INC;
                end
            end

            S_PUT:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.wa_sel = tcw_pkg::WA_CURSOR;
                ctrl.wd_sel = tcw_pkg::WD_HELD_CHAR;
                ctrl.col_op = tcw_pkg::COL_INC;
                state_next  = S_FINISH;
            end

            S_BS_FIRST:
            begin
                if (!status.rd_space)
                begin
                    ctrl.wr_en  = 1'b1;
                    ctrl.wa_sel = tcw_pkg::WA_CURSOR;
                    ctrl.wd_sel = tcw_pkg::WD_BLANK;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_BS_RD;
                end
            end

            S_BS_RD:
            begin
                // column bound before the cell to the left is fetched
                if (status.col_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ctrl.rd_en  = 1'b1;
                    ctrl.ra_sel = tcw_pkg::RA_CURSOR_M1;
                    state_next  = S_BS_CHK;
                end
            end

            S_BS_CHK:
            begin
                if (status.rd_space)
                begin
                    ctrl.col_op = tcw_pkg::COL_DEC;
                    state_next  = S_BS_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    ctrl.load_result = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctrl.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            then_put_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            then_put_reg  <= then_put_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

### test/console_shadow_check.sv
// Shadow screen model of the text console writer: predicts and checks every result word
module console_shadow_check #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
    input  logic  clk,
    input  logic  rst_n,
    tcw_item_if   item,
    tcw_result_if result,
    tcw_cfg_if    cfg,
    output int    failures,
    output int    pending,
    output int    words_checked,
    output int    scrolls,
    output int    wraps,
    output int    row_start_backspaces
);
    import tcw_pkg::*;

    localparam int CELLS       = ROWS * COLUMNS;
    localparam int PRINT_LIMIT = 100;

    typedef struct packed {
        logic [POS_OUT_W-1:0] cursor_position;
        logic [CELL_W-1:0]    cell_value;
    } console_report_t;

    logic [CELL_W-1:0] screen [CELLS];
    int                cur_row;
    int                cur_col;
    logic [ATTR_W-1:0] attribute;
    console_report_t   awaited_reports [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        if (failures < PRINT_LIMIT)
            $display("%0t: %s wrong on result word %0d: got %0h, expected %0h",
                     $time, what, words_checked, got, want);
        failures++;
    endtask

    function automatic logic [CELL_W-1:0] blank_cell();
        return {attribute, CHAR_SPACE};
    endfunction

    function automatic bit holds_space(int idx);
        return screen[idx][CHAR_W-1:0] == CHAR_SPACE;
    endfunction

    function automatic void fill_screen(logic [CELL_W-1:0] v);
        for (int i = 0; i < CELLS; i++)
            screen[i] = v;
    endfunction

    function automatic void line_feed();
        cur_col = 0;
        if (cur_row >= ROWS - 1)
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++)
                screen[i] = blank_cell();
            cur_row = ROWS - 1;
            scrolls++;
        end
        else
        begin
            cur_row++;
        end
    endfunction

    function automatic void print_char(logic [CHAR_W-1:0] ch);
        if (ch == CHAR_LF)
        begin
            line_feed();
        end
        else if (ch == CHAR_CR)
        begin
            cur_col = 0;
        end
        else if (ch == CHAR_BS)
        begin
            if (cur_col > 0)
            begin
                cur_col--;
                screen[cur_row * COLUMNS + cur_col] = blank_cell();
            end
            else if (cur_row > 0)
            begin
                // back onto the row above: blank its last cell, or skip trailing blanks
                row_start_backspaces++;
                cur_row--;
                cur_col = COLUMNS - 1;
                if (!holds_space(cur_row * COLUMNS + cur_col))
                    screen[cur_row * COLUMNS + cur_col] = blank_cell();
                else
                    while (cur_col > 0 && holds_space(cur_row * COLUMNS + cur_col - 1))
                        cur_col--;
            end
        end
        else
        begin
            // deferred wrap: the row is only left when the next byte arrives
            if (cur_col >= COLUMNS)
            begin
                wraps++;
                line_feed();
            end
            screen[cur_row * COLUMNS + cur_col] = {attribute, ch};
            cur_col++;
        end
    endfunction

    function automatic console_report_t console_step(logic [CMD_W-1:0]     cmd,
                                                     logic [CHAR_W-1:0]    ch,
                                                     logic [ADDR_IN_W-1:0] addr);
        console_report_t rep;
        int              pos;
        rep.cell_value = '0;
        case (cmd)
            CMD_PRINT: print_char(ch);
            CMD_CLEAR:
            begin
                fill_screen(blank_cell());
                cur_row = 0;
                cur_col = 0;
            end
            CMD_READ:
            begin
                if (addr < CELLS)
                    rep.cell_value = screen[addr];
            end
            default: ;
        endcase
        pos = cur_row * COLUMNS + cur_col;
        rep.cursor_position = pos[POS_OUT_W-1:0];
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        console_report_t got;
        console_report_t want;
        if (!rst_n)
        begin
            attribute = ATTR_RESET;
            fill_screen({ATTR_RESET, CHAR_SPACE});
            cur_row = 0;
            cur_col = 0;
            awaited_reports.delete();
            pending = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                attribute = cfg.text_attribute;
            // results first: a word leaving now belongs to an older item
            if (result.valid && result.ready)
            begin
                got.cursor_position = result.cursor_position;
                got.cell_value      = result.cell_value;
                if (awaited_reports.size() == 0)
                begin
                    report_mismatch("unexpected word, cursor_position",
                                    int'(got.cursor_position), 0);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    if (got.cursor_position !== want.cursor_position)
                        report_mismatch("cursor_position", int'(got.cursor_position),
                                        int'(want.cursor_position));
                    if (got.cell_value !== want.cell_value)
                        report_mismatch("cell_value", int'(got.cell_value),
                                        int'(want.cell_value));
                    words_checked++;
                end
            end
            if (item.valid && item.ready)
                awaited_reports.push_back(console_step(item.cmd, item.char_code,
                                                       item.cell_address));
            pending = awaited_reports.size();
        end
    end
endmodule

### test/text_console_writer_tb.sv
// Stimulus, flow control and verdict for the text console writer
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS     = COLUMNS_DEFAULT;
    localparam int ROWS        = ROWS_DEFAULT;
    localparam int CELLS       = ROWS * COLUMNS;
    localparam int ADDR_TOP    = (1 << ADDR_IN_W) - 1;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 250;
    localparam int LONG_HOLD   = 400;

    logic clk;
    logic rst_n;

    tcw_item_if   item_ch ();
    tcw_result_if result_ch ();
    tcw_cfg_if    cfg_ch ();

    int failures;
    int pending;
    int words_checked;
    int scrolls;
    int wraps;
    int row_start_backspaces;

    int words_sent    = 0;
    int burst_left    = 0;
    int gap_max       = 3;
    int hold_requests = 0;
    int holds_served  = 0;
    int quiet_cycles  = 0;

    text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    console_shadow_check #(.COLUMNS(COLUMNS), .ROWS(ROWS)) shadow (
        .clk                  (clk),
        .rst_n                (rst_n),
        .item                 (item_ch),
        .result               (result_ch),
        .cfg                  (cfg_ch),
        .failures             (failures),
        .pending              (pending),
        .words_checked        (words_checked),
        .scrolls              (scrolls),
        .wraps                (wraps),
        .row_start_backspaces (row_start_backspaces)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on handshake activity of any channel
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("No handshake for %0d cycles, giving up", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result receiver: stall pattern changes mode now and then, long hold on request
    initial
    begin : receiver
        int mode;
        int mode_left;
        int step;
        result_ch.ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        step      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_served)
            begin
                result_ch.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                holds_served++;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            step++;
            case (mode)
                0:       result_ch.ready = 1'b1;
                1:       result_ch.ready = ($urandom_range(0, 9) < 6);
                2:       result_ch.ready = ((step % 5) < 3);
                default: result_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_word(input logic [CMD_W-1:0]     cmd,
                             input logic [CHAR_W-1:0]    ch,
                             input logic [ADDR_IN_W-1:0] addr);
        int gap;
        if (burst_left <= 0)
        begin
            gap = (gap_max > 0) ? $urandom_range(1, gap_max) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                item_ch.valid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        item_ch.valid        = 1'b1;
        item_ch.cmd          = cmd;
        item_ch.char_code    = ch;
        item_ch.cell_address = addr;
        do @(posedge clk); while (!item_ch.ready);
        burst_left--;
        words_sent++;
    endtask

    // stop offering, then wait until every awaited word is back
    task automatic drain();
        @(negedge clk);
        item_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid          = 1'b1;
        cfg_ch.text_attribute = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] pick_glyph();
        logic [CHAR_W-1:0] g;
        if ($urandom_range(0, 3) == 0)
            return CHAR_SPACE;
        do g = CHAR_W'($urandom_range(0, 255));
        while (g == CHAR_LF || g == CHAR_CR || g == CHAR_BS);
        return g;
    endfunction

    function automatic logic [ADDR_IN_W-1:0] any_addr();
        return ADDR_IN_W'($urandom);
    endfunction

    function automatic logic [CHAR_W-1:0] any_char();
        return CHAR_W'($urandom);
    endfunction

    // one line of text, often with trailing blanks and a backspace across the row start
    task automatic type_line();
        int len;
        int tail;
        int ending;
        len    = ($urandom_range(0, 2) == 0) ? COLUMNS : $urandom_range(0, COLUMNS + 10);
        tail   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        ending = $urandom_range(0, 9);
        repeat (len) send_word(CMD_PRINT, pick_glyph(), any_addr());
        repeat (tail) send_word(CMD_PRINT, CHAR_SPACE, any_addr());
        if (ending <= 4)
        begin
            send_word(CMD_PRINT, CHAR_LF, any_addr());
        end
        else if (ending == 5)
        begin
            send_word(CMD_PRINT, CHAR_CR, any_addr());
        end
        else if (ending <= 8)
        begin
            send_word(CMD_PRINT, CHAR_LF, any_addr());
            repeat ($urandom_range(1, 3)) send_word(CMD_PRINT, CHAR_BS, any_addr());
        end
    endtask

    task automatic read_cells();
        repeat ($urandom_range(1, 4))
            send_word(CMD_READ, any_char(),
                      ($urandom_range(0, 4) == 0) ?
                          ADDR_IN_W'($urandom_range(CELLS, ADDR_TOP)) :
                          ADDR_IN_W'($urandom_range(0, CELLS - 1)));
    endtask

    initial
    begin : stimulus
        int               phase_start;
        int               pick;
        bit               held;
        logic [ATTR_W-1:0] attr;

        rst_n                 = 1'b0;
        item_ch.valid         = 1'b0;
        item_ch.cmd           = CMD_PRINT;
        item_ch.char_code     = '0;
        item_ch.cell_address  = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.text_attribute = '0;
        held                  = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words at the reset attribute
        send_word(CMD_READ, 8'h00, '0);
        send_word(CMD_READ, 8'h00, ADDR_IN_W'(CELLS - 1));
        send_word(CMD_READ, 8'h00, ADDR_IN_W'(CELLS));
        send_word(CMD_READ, 8'hFF, ADDR_IN_W'(ADDR_TOP));
        send_word(CMD_NONE, 8'hFF, ADDR_IN_W'(ADDR_TOP));
        send_word(CMD_PRINT, 8'h00, '0);
        send_word(CMD_PRINT, 8'hFF, '0);
        send_word(CMD_PRINT, CHAR_SPACE, '0);
        send_word(CMD_PRINT, CHAR_BS, '0);
        send_word(CMD_PRINT, CHAR_CR, '0);
        send_word(CMD_PRINT, CHAR_BS, '0);
        send_word(CMD_PRINT, 8'h41, '0);
        send_word(CMD_PRINT, CHAR_LF, '0);
        // row above ends in blanks: cursor walks back to just after the last printed cell
        send_word(CMD_PRINT, CHAR_BS, '0);
        send_word(CMD_READ, 8'h00, '0);
        send_word(CMD_READ, 8'h00, ADDR_IN_W'(1));
        send_word(CMD_CLEAR, 8'hFF, ADDR_IN_W'(ADDR_TOP));
        send_word(CMD_READ, 8'h00, ADDR_IN_W'(1));
        send_word(CMD_PRINT, CHAR_CR, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0:       attr = 8'h00;
                1:       attr = 8'hFF;
                2:       attr = 8'hA5;
                3:       attr = 8'h5A;
                default: attr = ATTR_W'($urandom);
            endcase
            write_attribute(attr);
            gap_max     = (p % 3 == 1) ? 0 : ((p % 3 == 2) ? 12 : 4);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
            begin
                // long receiver hold while words keep coming, so the input backs up
                if (p == 3 && !held && words_sent - phase_start > 60)
                begin
                    hold_requests++;
                    held = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 46)
                begin
                    type_line();
                end
                else if (pick < 52)
                begin
                    repeat (COLUMNS) send_word(CMD_PRINT, pick_glyph(), any_addr());
                    send_word(CMD_PRINT, CHAR_LF, any_addr());
                    repeat ($urandom_range(1, 2)) send_word(CMD_PRINT, CHAR_BS, any_addr());
                end
                else if (pick < 62)
                begin
                    repeat ($urandom_range(1, 8)) send_word(CMD_PRINT, CHAR_BS, any_addr());
                end
                else if (pick < 80)
                begin
                    read_cells();
                end
                else if (pick < 84)
                begin
                    send_word(CMD_CLEAR, any_char(), any_addr());
                end
                else if (pick < 88)
                begin
                    send_word(CMD_NONE, any_char(), any_addr());
                end
                else if (pick < 95)
                begin
                    repeat ($urandom_range(1, 3))
                        send_word(CMD_W'($urandom_range(0, 3)), any_char(), any_addr());
                end
                else
                begin
                    repeat ($urandom_range(1, 6)) send_word(CMD_PRINT, CHAR_LF, any_addr());
                end
            end
        end

        drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d words over %0d attribute settings, %0d result words compared.",
                 words_sent, PHASES + 1, words_checked);
        $display("Seen: %0d scrolls, %0d deferred wraps, %0d backspaces over a row start.",
                 scrolls, wraps, row_start_backspaces);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
